[src/tkz_pkg.sv]
// shared token types and codes for the charstring tokenizer
package tkz_pkg;

  localparam logic [1:0] KIND_OPERAND = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_MASK = 2'd2;

  localparam logic [8:0] OP_RETURN = 9'd11;
  localparam logic [8:0] OP_ENDCHAR = 9'd14;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [8:0]  op_code;
    logic        reserved;
    logic        last;
  } token_t;

endpackage

[src/tkz_core.sv]
// tokenizer state registers and the per-byte decode logic
module tkz_core #(
  parameter int MAX_HINTS = 96,
  parameter int MAX_OPERANDS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  output logic            emit_o,
  output tkz_pkg::token_t tok_o
);

  localparam int HW = $clog2(MAX_HINTS + 1);
  localparam int OW = $clog2(MAX_OPERANDS + 1);
  localparam int SW = ((HW > OW) ? HW : OW) + 1;
  localparam int MW = HW + 1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TWO   = 3'd1,
    PH_SHORT = 3'd2,
    PH_FIXED = 3'd3,
    PH_ESC   = 3'd4,
    PH_MASK  = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      left_q, left_d;
  logic [7:0]      lead_q, lead_d;
  logic [31:0]     acc_q, acc_d;
  logic [HW-1:0]   hint_q, hint_d;
  logic [OW-1:0]   opc_q, opc_d;
  logic [3:0]      mask_q, mask_d;

  logic [SW-1:0]   hsum;
  logic [HW-1:0]   hint_add;
  logic [MW-1:0]   msum;
  logic [MW-1:0]   nbytes;
  logic [OW-1:0]   opc_inc;
  logic [31:0]     acc_sh;
  logic [31:0]     mag;

  function automatic logic single_rsv(input logic [7:0] v);
    single_rsv = (v == 8'd0) || (v == 8'd2) || (v == 8'd9) || (v == 8'd13) ||
                 (v == 8'd15) || (v == 8'd16) || (v == 8'd17);
  endfunction

  function automatic logic esc_rsv(input logic [7:0] w);
    logic ok;
    case (w) inside
      8'd0, 8'd3, 8'd4, 8'd5, 8'd9, 8'd10, 8'd11, 8'd12, 8'd14, 8'd15, 8'd18,
      [8'd20:8'd24], [8'd26:8'd30], [8'd34:8'd37]: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    esc_rsv = !ok;
  endfunction

  // hint count from implicit and explicit stem pairs, mask byte count, operand count and byte shift
  always_comb begin
    hsum = SW'(hint_q) + SW'(opc_q >> 1);
    if (hsum > SW'(MAX_HINTS)) begin
      hint_add = HW'(MAX_HINTS);
    end else begin
      hint_add = hsum[HW-1:0];
    end
    msum = MW'(hint_add) + MW'(7);
    nbytes = msum >> 3;
    if (opc_q < OW'(MAX_OPERANDS)) begin
      opc_inc = opc_q + OW'(1);
    end else begin
      opc_inc = opc_q;
    end
    acc_sh = {acc_q[23:0], byte_i};
  end

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    lead_d  = lead_q;
    acc_d   = acc_q;
    hint_d  = hint_q;
    opc_d   = opc_q;
    mask_d  = mask_q;
    emit_o  = 1'b0;
    mag     = '0;
    tok_o   = '{kind: tkz_pkg::KIND_OPERAND, value: '0, op_code: '0,
                reserved: 1'b0, last: 1'b0};
    case (phase_q)
      PH_TWO: begin
        phase_d = PH_IDLE;
        left_d  = '0;
        emit_o  = 1'b1;
        opc_d   = opc_inc;
        if (lead_q < 8'd251) begin
          mag = ((32'(lead_q) - 32'd247) << 8) + 32'(byte_i) + 32'd108;
          tok_o.value = mag;
        end else begin
          mag = ((32'(lead_q) - 32'd251) & 32'd3) * 32'd256 + 32'(byte_i) + 32'd108;
          tok_o.value = 32'd0 - mag;
        end
      end
      PH_SHORT, PH_FIXED: begin
        acc_d = acc_sh;
        if (left_q > 3'd1) begin
          left_d = left_q - 3'd1;
        end else begin
          left_d  = '0;
          phase_d = PH_IDLE;
          acc_d   = '0;
          emit_o  = 1'b1;
          opc_d   = opc_inc;
          if (phase_q == PH_SHORT) begin
            tok_o.value = {{16{acc_sh[15]}}, acc_sh[15:0]};
          end else begin
            tok_o.value = acc_sh;
          end
        end
      end
      PH_ESC: begin
        phase_d        = PH_IDLE;
        opc_d          = '0;
        emit_o         = 1'b1;
        tok_o.kind     = tkz_pkg::KIND_OPERATOR;
        tok_o.op_code  = {1'b1, byte_i};
        tok_o.reserved = esc_rsv(byte_i);
      end
      PH_MASK: begin
        mask_d = (mask_q > 4'd0) ? mask_q - 4'd1 : mask_q;
        if (mask_d == 4'd0) begin
          phase_d = PH_IDLE;
        end
        emit_o      = 1'b1;
        tok_o.kind  = tkz_pkg::KIND_MASK;
        tok_o.value = 32'(byte_i);
      end
      default: begin
        phase_d = PH_IDLE;
        case (byte_i) inside
          [8'd32:8'd246]: begin
            emit_o      = 1'b1;
            opc_d       = opc_inc;
            tok_o.value = 32'(byte_i) - 32'd139;
          end
          [8'd247:8'd254]: begin
            lead_d  = byte_i;
            phase_d = PH_TWO;
            left_d  = 3'd1;
          end
          8'd255: begin
            acc_d   = '0;
            phase_d = PH_FIXED;
            left_d  = 3'd4;
          end
          8'd28: begin
            acc_d   = '0;
            phase_d = PH_SHORT;
            left_d  = 3'd2;
          end
          8'd12: begin
            phase_d = PH_ESC;
          end
          8'd11, 8'd14: begin
            phase_d       = PH_IDLE;
            left_d        = '0;
            lead_d        = '0;
            acc_d         = '0;
            hint_d        = '0;
            opc_d         = '0;
            mask_d        = '0;
            emit_o        = 1'b1;
            tok_o.kind    = tkz_pkg::KIND_OPERATOR;
            tok_o.op_code = 9'(byte_i);
            tok_o.last    = 1'b1;
          end
          8'd1, 8'd3, 8'd18, 8'd23: begin
            hint_d        = hint_add;
            opc_d         = '0;
            emit_o        = 1'b1;
            tok_o.kind    = tkz_pkg::KIND_OPERATOR;
            tok_o.op_code = 9'(byte_i);
          end
          8'd19, 8'd20: begin
            hint_d = hint_add;
            opc_d  = '0;
            if (nbytes > MW'(15)) begin
              mask_d = 4'd15;
            end else begin
              mask_d = nbytes[3:0];
            end
            phase_d       = (mask_d != 4'd0) ? PH_MASK : PH_IDLE;
            emit_o        = 1'b1;
            tok_o.kind    = tkz_pkg::KIND_OPERATOR;
            tok_o.op_code = 9'(byte_i);
          end
          default: begin
            opc_d          = '0;
            emit_o         = 1'b1;
            tok_o.kind     = tkz_pkg::KIND_OPERATOR;
            tok_o.op_code  = 9'(byte_i);
            tok_o.reserved = single_rsv(byte_i);
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= '0;
      lead_q  <= '0;
      acc_q   <= '0;
      hint_q  <= '0;
      opc_q   <= '0;
      mask_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      lead_q  <= lead_d;
      acc_q   <= acc_d;
      hint_q  <= hint_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
    end
  end

endmodule

[src/tkz_outbuf.sv]
// output register with skid stage for result tokens
module tkz_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  tkz_pkg::token_t tok_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tkz_pkg::token_t out_o
);

  logic            out_valid_q;
  logic            skid_valid_q;
  tkz_pkg::token_t out_q;
  tkz_pkg::token_t skid_q;
  logic            free;

  assign free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= tok_valid_i;
      end
    end else if (tok_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      out_q <= skid_valid_q ? skid_q : tok_i;
    end
    if (!free && tok_valid_i) begin
      skid_q <= tok_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[src/type2_charstring_tokenizer_top.sv]
// top level of the type 2 charstring tokenizer
//
//   channel | direction | payload                                        | handshake
//   in      | input     | byte_in_i                                      | in_valid_i / in_stall_o
//   out     | output    | token_kind_o value_o op_code_o reserved_op_o   | out_valid_o / out_stall_i
//           |           | last_token_o                                   |
//
// one byte per cycle while in_stall_o is low; a completed token is registered in the output buffer
// state update and decode are combinational logic ahead of the output register
// a two-entry output buffer keeps input flowing while its skid entry is free
// in_stall_o rises only when both output entries are full
// asynchronous reset returns all tokenizer state to idle with no tokens pending
module type2_charstring_tokenizer_top #(
  parameter int MAX_HINTS = 96,
  parameter int MAX_OPERANDS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         token_kind_o,
  output logic signed [31:0] value_o,
  output logic [8:0]         op_code_o,
  output logic               reserved_op_o,
  output logic               last_token_o
);

  logic            accept;
  logic            emit;
  logic            full;
  tkz_pkg::token_t tok;
  tkz_pkg::token_t out_tok;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  tkz_core #(
    .MAX_HINTS   (MAX_HINTS),
    .MAX_OPERANDS(MAX_OPERANDS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (byte_in_i),
    .emit_o  (emit),
    .tok_o   (tok)
  );

  tkz_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(accept && emit),
    .tok_i      (tok),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_tok)
  );

  assign token_kind_o  = out_tok.kind;
  assign value_o       = signed'(out_tok.value);
  assign op_code_o     = out_tok.op_code;
  assign reserved_op_o = out_tok.reserved;
  assign last_token_o  = out_tok.last;

endmodule

[src/tkz_checker.sv]
// port-level checks for the charstring tokenizer, bound to the top level
module tkz_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [7:0]         byte_in_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         token_kind_o,
  input logic signed [31:0] value_o,
  input logic [8:0]         op_code_o,
  input logic               reserved_op_o,
  input logic               last_token_o
);

  // stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o != 2'd3)
    else $error("illegal token kind");

  a_non_op_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != tkz_pkg::KIND_OPERATOR |->
      op_code_o == 9'd0 && !reserved_op_o && !last_token_o)
    else $error("operator fields set on a non-operator token");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_token_o |->
      token_kind_o == tkz_pkg::KIND_OPERATOR &&
      (op_code_o == tkz_pkg::OP_RETURN || op_code_o == tkz_pkg::OP_ENDCHAR))
    else $error("last token is not return or endchar");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind type2_charstring_tokenizer_top tkz_checker u_tkz_checker (.*);

[dv/tkz_tb_pkg.sv]
// charstring byte codes shared by the tokenizer testbench and its checker
package tkz_tb_pkg;

  localparam logic [7:0] CS_HSTEM     = 8'd1;
  localparam logic [7:0] CS_VSTEM     = 8'd3;
  localparam logic [7:0] CS_RETURN    = 8'd11;
  localparam logic [7:0] CS_ESCAPE    = 8'd12;
  localparam logic [7:0] CS_ENDCHAR   = 8'd14;
  localparam logic [7:0] CS_HSTEMHM   = 8'd18;
  localparam logic [7:0] CS_HINTMASK  = 8'd19;
  localparam logic [7:0] CS_CNTRMASK  = 8'd20;
  localparam logic [7:0] CS_VSTEMHM   = 8'd23;
  localparam logic [7:0] CS_SHORTINT  = 8'd28;
  localparam logic [7:0] CS_LAST_OP   = 8'd31;
  localparam logic [7:0] CS_INT_LO    = 8'd32;
  localparam logic [7:0] CS_INT_HI    = 8'd246;
  localparam logic [7:0] CS_POS_LO    = 8'd247;
  localparam logic [7:0] CS_POS_HI    = 8'd250;
  localparam logic [7:0] CS_NEG_LO    = 8'd251;
  localparam logic [7:0] CS_NEG_HI    = 8'd254;
  localparam logic [7:0] CS_FIXED     = 8'd255;
  localparam logic [7:0] CS_ESC_KNOWN = 8'd38;

endpackage

[dv/type2_charstring_tokenizer_checker.sv]
// token predictor and scoreboard for the charstring tokenizer channels
module type2_charstring_tokenizer_checker #(
  parameter int MAX_HINTS = 96,
  parameter int MAX_OPERANDS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         byte_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         token_kind_i,
  input  logic signed [31:0] value_i,
  input  logic [8:0]         op_code_i,
  input  logic               reserved_op_i,
  input  logic               last_token_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] OPERAND_BIAS   = 32'd139;
  localparam logic [31:0] OPERAND_OFFSET = 32'd108;
  localparam logic [8:0]  ESCAPE_BASE    = 9'd256;
  localparam int          MASK_BYTES_MAX = 15;
  // reserved single-byte operators and assigned escaped operators, one bit per code
  localparam logic [31:0] SINGLE_RESERVED = 32'h0003_A205;
  localparam logic [37:0] ESC_ASSIGNED    = 38'h3C_7DF4_DE39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWO,
    ST_SHORT,
    ST_FIXED,
    ST_ESC,
    ST_MASK
  } parse_state_e;

  parse_state_e parse_state;
  logic [2:0]   operand_bytes_left;
  logic [7:0]   lead_q;
  logic [31:0]  gather_q;
  logic [6:0]   hints_q;
  logic [5:0]   pending_operands_q;
  logic [3:0]   mask_left_q;

  tkz_pkg::token_t expected_tokens[$];
  tkz_pkg::token_t predicted_tok;
  tkz_pkg::token_t oldest_tok;
  tkz_pkg::token_t observed_tok;

  function automatic void clear_state();
    parse_state = ST_IDLE;
    operand_bytes_left = '0;
    lead_q = '0;
    gather_q = '0;
    hints_q = '0;
    pending_operands_q = '0;
    mask_left_q = '0;
  endfunction

  function automatic void push_operand(output tkz_pkg::token_t tok, input logic [31:0] v);
    if (pending_operands_q < MAX_OPERANDS) pending_operands_q++;
    tok = '0;
    tok.kind = tkz_pkg::KIND_OPERAND;
    tok.value = v;
  endfunction

  function automatic void add_hints();
    int h;
    h = hints_q + pending_operands_q / 2;
    if (h > MAX_HINTS) h = MAX_HINTS;
    hints_q = h[6:0];
    pending_operands_q = '0;
  endfunction

  // returns 1 when the byte completes a token
  function automatic logic tokenize_byte(input logic [7:0] b, output tkz_pkg::token_t tok);
    logic [31:0] mag;
    int nb;
    tok = '0;
    case (parse_state)
      ST_TWO: begin
        parse_state = ST_IDLE;
        operand_bytes_left = '0;
        if (lead_q < tkz_tb_pkg::CS_NEG_LO) begin
          mag = (32'(lead_q) - 32'(tkz_tb_pkg::CS_POS_LO)) * 32'd256 + 32'(b) +
                OPERAND_OFFSET;
          push_operand(tok, mag);
        end else begin
          mag = ((32'(lead_q) - 32'(tkz_tb_pkg::CS_NEG_LO)) & 32'd3) * 32'd256 +
                32'(b) + OPERAND_OFFSET;
          push_operand(tok, 32'd0 - mag);
        end
        return 1'b1;
      end
      ST_SHORT, ST_FIXED: begin
        gather_q = {gather_q[23:0], b};
        if (operand_bytes_left > 1) begin
          operand_bytes_left--;
          return 1'b0;
        end
        operand_bytes_left = '0;
        if (parse_state == ST_SHORT) begin
          push_operand(tok, {{16{gather_q[15]}}, gather_q[15:0]});
        end else begin
          push_operand(tok, gather_q);
        end
        parse_state = ST_IDLE;
        gather_q = '0;
        return 1'b1;
      end
      ST_ESC: begin
        parse_state = ST_IDLE;
        pending_operands_q = '0;
        tok.kind = tkz_pkg::KIND_OPERATOR;
        tok.op_code = ESCAPE_BASE + 9'(b);
        tok.reserved = (b >= tkz_tb_pkg::CS_ESC_KNOWN) ? 1'b1 : !ESC_ASSIGNED[b[5:0]];
        return 1'b1;
      end
      ST_MASK: begin
        if (mask_left_q > 0) mask_left_q--;
        if (mask_left_q == 0) parse_state = ST_IDLE;
        tok.kind = tkz_pkg::KIND_MASK;
        tok.value = 32'(b);
        return 1'b1;
      end
      default: ;
    endcase

    // lead byte
    parse_state = ST_IDLE;
    if (b >= tkz_tb_pkg::CS_INT_LO && b <= tkz_tb_pkg::CS_INT_HI) begin
      push_operand(tok, 32'(b) - OPERAND_BIAS);
      return 1'b1;
    end
    if (b >= tkz_tb_pkg::CS_POS_LO && b <= tkz_tb_pkg::CS_NEG_HI) begin
      lead_q = b;
      parse_state = ST_TWO;
      operand_bytes_left = 3'd1;
      return 1'b0;
    end
    if (b == tkz_tb_pkg::CS_FIXED) begin
      gather_q = '0;
      parse_state = ST_FIXED;
      operand_bytes_left = 3'd4;
      return 1'b0;
    end
    if (b == tkz_tb_pkg::CS_SHORTINT) begin
      gather_q = '0;
      parse_state = ST_SHORT;
      operand_bytes_left = 3'd2;
      return 1'b0;
    end
    if (b == tkz_tb_pkg::CS_ESCAPE) begin
      parse_state = ST_ESC;
      return 1'b0;
    end
    tok.kind = tkz_pkg::KIND_OPERATOR;
    tok.op_code = 9'(b);
    if (b == tkz_tb_pkg::CS_RETURN || b == tkz_tb_pkg::CS_ENDCHAR) begin
      clear_state();
      tok.last = 1'b1;
      return 1'b1;
    end
    if (b == tkz_tb_pkg::CS_HSTEM || b == tkz_tb_pkg::CS_VSTEM ||
        b == tkz_tb_pkg::CS_HSTEMHM || b == tkz_tb_pkg::CS_VSTEMHM) begin
      add_hints();
      return 1'b1;
    end
    if (b == tkz_tb_pkg::CS_HINTMASK || b == tkz_tb_pkg::CS_CNTRMASK) begin
      // pending operands count as implicit vstem pairs
      add_hints();
      nb = (hints_q + 7) / 8;
      if (nb > MASK_BYTES_MAX) nb = MASK_BYTES_MAX;
      mask_left_q = nb[3:0];
      parse_state = (nb != 0) ? ST_MASK : ST_IDLE;
      return 1'b1;
    end
    pending_operands_q = '0;
    tok.reserved = SINGLE_RESERVED[b[4:0]];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (a !== e) begin
      errors_o++;
      $error("%s: expected %0d, actual %0d", name, $signed(e), $signed(a));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_tokens.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        observed_tok = '{token_kind_i, value_i, op_code_i, reserved_op_i, last_token_i};
        if (expected_tokens.size() == 0) begin
          errors_o++;
          $error("token_kind: expected none, actual %0d (no transaction pending)",
                 token_kind_i);
        end else begin
          oldest_tok = expected_tokens.pop_front();
          check_field("token_kind", 32'(oldest_tok.kind), 32'(observed_tok.kind));
          check_field("value", oldest_tok.value, observed_tok.value);
          check_field("op_code", 32'(oldest_tok.op_code), 32'(observed_tok.op_code));
          check_field("reserved_op", 32'(oldest_tok.reserved), 32'(observed_tok.reserved));
          check_field("last_token", 32'(oldest_tok.last), 32'(observed_tok.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (tokenize_byte(byte_in_i, predicted_tok)) expected_tokens.push_back(predicted_tok);
      end
      pending_o = expected_tokens.size();
    end
  end

endmodule

[dv/tb_type2_charstring_tokenizer_top.sv]
// stimulus and verdict for the type 2 charstring tokenizer
module tb_type2_charstring_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_HINTS     = 96;
  localparam int MAX_OPERANDS  = 48;
  localparam int RANDOM_BYTES  = 1450;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MASK_BYTES_MAX = 15;

  localparam logic [7:0] STEM_OPS[4] = '{tkz_tb_pkg::CS_HSTEM, tkz_tb_pkg::CS_VSTEM,
                                         tkz_tb_pkg::CS_HSTEMHM, tkz_tb_pkg::CS_VSTEMHM};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         byte_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         token_kind_o;
  logic signed [31:0] value_o;
  logic [8:0]         op_code_o;
  logic               reserved_op_o;
  logic               last_token_o;

  int errors;
  int pending;
  int cycle_count;
  int sent_bytes;
  int quiet_left;
  int hints_seen;
  int operands_seen;

  logic [7:0] directed_bytes[$] = '{
    tkz_tb_pkg::CS_INT_LO, tkz_tb_pkg::CS_INT_HI, 8'd139,
    tkz_tb_pkg::CS_POS_LO, 8'h00, tkz_tb_pkg::CS_POS_HI, 8'hFF,
    tkz_tb_pkg::CS_NEG_LO, 8'h00, tkz_tb_pkg::CS_NEG_HI, 8'hFF,
    tkz_tb_pkg::CS_SHORTINT, 8'h80, 8'h00, tkz_tb_pkg::CS_SHORTINT, 8'h7F, 8'hFF,
    tkz_tb_pkg::CS_FIXED, 8'h80, 8'h00, 8'h00, 8'h00,
    tkz_tb_pkg::CS_FIXED, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
    8'h00, tkz_tb_pkg::CS_ESCAPE, 8'h00, tkz_tb_pkg::CS_ESCAPE, 8'hFF,
    8'd139, 8'd139, tkz_tb_pkg::CS_HINTMASK, 8'hA5, tkz_tb_pkg::CS_ENDCHAR,
    tkz_tb_pkg::CS_CNTRMASK, tkz_tb_pkg::CS_RETURN
  };

  type2_charstring_tokenizer_top #(
    .MAX_HINTS(MAX_HINTS),
    .MAX_OPERANDS(MAX_OPERANDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .value_o      (value_o),
    .op_code_o    (op_code_o),
    .reserved_op_o(reserved_op_o),
    .last_token_o (last_token_o)
  );

  type2_charstring_tokenizer_checker #(
    .MAX_HINTS(MAX_HINTS),
    .MAX_OPERANDS(MAX_OPERANDS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_i (token_kind_o),
    .value_i      (value_o),
    .op_code_i    (op_code_o),
    .reserved_op_i(reserved_op_o),
    .last_token_i (last_token_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_type2_charstring_tokenizer_top: errors");
      $finish;
    end
  end

  // receiver stall: short bursts, a few long ones, and stretches without stall
  initial begin
    int stall_left;
    int free_left;
    int pick;
    stall_left = 0;
    free_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && free_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) free_left = $urandom_range(1, 4);
        else if (pick < 50) free_left = $urandom_range(30, 120);
        else if (pick < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 24);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        free_left--;
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) quiet_left = $urandom_range(20, 80);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_operand();
    int form;
    logic [31:0] raw;
    form = $urandom_range(0, 9);
    raw = $urandom;
    if (operands_seen < MAX_OPERANDS) operands_seen++;
    if (form < 5) begin
      send_byte(8'($urandom_range(tkz_tb_pkg::CS_INT_LO, tkz_tb_pkg::CS_INT_HI)));
    end else if (form < 7) begin
      send_byte(8'($urandom_range(tkz_tb_pkg::CS_POS_LO, tkz_tb_pkg::CS_POS_HI)));
      send_byte(raw[7:0]);
    end else if (form < 8) begin
      send_byte(8'($urandom_range(tkz_tb_pkg::CS_NEG_LO, tkz_tb_pkg::CS_NEG_HI)));
      send_byte(raw[7:0]);
    end else if (form < 9) begin
      send_byte(tkz_tb_pkg::CS_SHORTINT);
      send_byte(raw[15:8]);
      send_byte(raw[7:0]);
    end else begin
      send_byte(tkz_tb_pkg::CS_FIXED);
      send_byte(raw[31:24]);
      send_byte(raw[23:16]);
      send_byte(raw[15:8]);
      send_byte(raw[7:0]);
    end
  endtask

  task automatic send_operands(input int n);
    repeat (n) send_operand();
  endtask

  function automatic void note_hints();
    hints_seen = hints_seen + operands_seen / 2;
    if (hints_seen > MAX_HINTS) hints_seen = MAX_HINTS;
    operands_seen = 0;
  endfunction

  task automatic send_stem();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) send_operands(2 * $urandom_range(1, 6));
    else if (pick < 85) send_operands(2 * $urandom_range(0, 6) + 1);
    else if (pick < 95) send_operands($urandom_range(40, 52));
    note_hints();
    send_byte(STEM_OPS[$urandom_range(0, 3)]);
  endtask

  task automatic send_mask();
    int nb;
    send_operands($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0);
    note_hints();
    nb = (hints_seen + 7) / 8;
    if (nb > MASK_BYTES_MAX) nb = MASK_BYTES_MAX;
    send_byte($urandom_range(0, 1) ? tkz_tb_pkg::CS_HINTMASK : tkz_tb_pkg::CS_CNTRMASK);
    repeat (nb) send_byte(8'($urandom));
  endtask

  task automatic send_path_op();
    logic [7:0] op;
    send_operands($urandom_range(0, 29) == 0 ? $urandom_range(44, 52) : $urandom_range(0, 6));
    if ($urandom_range(0, 4) == 0) begin
      operands_seen = 0;
      send_byte(tkz_tb_pkg::CS_ESCAPE);
      send_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
                   $urandom_range(0, tkz_tb_pkg::CS_ESC_KNOWN)));
    end else begin
      do op = 8'($urandom_range(0, tkz_tb_pkg::CS_LAST_OP));
      while (op == tkz_tb_pkg::CS_ESCAPE || op == tkz_tb_pkg::CS_SHORTINT ||
             op == tkz_tb_pkg::CS_RETURN || op == tkz_tb_pkg::CS_ENDCHAR ||
             op == tkz_tb_pkg::CS_HINTMASK || op == tkz_tb_pkg::CS_CNTRMASK);
      if (op == tkz_tb_pkg::CS_HSTEM || op == tkz_tb_pkg::CS_VSTEM ||
          op == tkz_tb_pkg::CS_HSTEMHM || op == tkz_tb_pkg::CS_VSTEMHM) begin
        note_hints();
      end else begin
        operands_seen = 0;
      end
      send_byte(op);
    end
  endtask

  task automatic send_charstring();
    int pick;
    hints_seen = 0;
    operands_seen = 0;
    repeat ($urandom_range(0, 4)) send_stem();
    if ($urandom_range(0, 2) == 0) send_mask();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 3) == 0) send_mask();
      else send_path_op();
    end
    pick = $urandom_range(0, 19);
    // an unterminated charstring runs into the next one
    if (pick != 0) send_byte(pick[0] ? tkz_tb_pkg::CS_RETURN : tkz_tb_pkg::CS_ENDCHAR);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    byte_in_i = '0;
    cycle_count = 0;
    sent_bytes = 0;
    quiet_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end else begin
        send_charstring();
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_type2_charstring_tokenizer_top: clean");
    end else begin
      $display("tb_type2_charstring_tokenizer_top: errors");
    end
    $finish;
  end

endmodule
